@@ rtl/core/fcsg_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the filled circle span generator.
package fcsg_pkg;

    localparam int RADIUS_W        = 7;
    localparam int ROOT_W          = RADIUS_W;
    localparam int PROD_W          = 2 * RADIUS_W;
    localparam int COLOR_W         = 32;
    localparam int COORD_WIDTH_DEF = 12;
    localparam int RADIUS_MAX_DEF  = 64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ROOT,
        ST_OUT
    } fcsg_state_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } fcsg_root_t;

endpackage

@@ rtl/core/fcsg_isqrt.sv @@
`timescale 1ns / 1ps
// Iterative integer square root, one result bit per cycle.
module fcsg_isqrt
    import fcsg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [PROD_W-1:0] operand,
    output fcsg_root_t        result
);

    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ROOT_W);

    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] q_reg, q_next;
    logic [PROD_W-1:0] rad_reg, rad_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    // bring down the next bit pair and try (2q << 1) | 1
    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[PROD_W-1 -: 2]};
    assign trial  = {1'b0, q_reg, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_comb begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        rad_next  = rad_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            q_next    = '0;
            rad_next  = operand;
            cnt_next  = CNT_W'(ROOT_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? (rem_sh - trial) : rem_sh;
            q_next   = {q_reg[ROOT_W-2:0], ge};
            rad_next = {rad_reg[PROD_W-3:0], 2'b00};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        rad_reg <= rad_next;
        cnt_reg <= cnt_next;
    end

    assign result.done = done_reg;
    assign result.root = q_reg;

endmodule

@@ rtl/core/filled_circle_span_generator.sv @@
`timescale 1ns / 1ps
// Filled circle span generator: sequencer, span arithmetic and result register.
//
//  channel | direction | ports                                          | handshake
//  s_      | in        | center_x, center_y, radius, fill_color         | s_valid/s_ready
//  m_      | out       | row_below, row_above, span_left, span_right,   | m_valid/m_ready
//          |           | color_out, last_span                           |
//
// Each span pair runs through the multiply, the bit-serial square root unit,
// a load of the result register and the hand-over in the output state.
// s_ready is high only while idle; a zero radius returns to idle at once.
// A stalled m_ready holds the sequencer in the output state.
// Reset clears the sequencer and the square root unit's control.
module filled_circle_span_generator
    import fcsg_pkg::*;
#(
    parameter int RADIUS_MAX  = RADIUS_MAX_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_center_x,
    input  logic signed [COORD_WIDTH-1:0] s_center_y,
    input  logic        [RADIUS_W-1:0]    s_radius,
    input  logic        [COLOR_W-1:0]     s_fill_color,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH:0]   m_row_below,
    output logic signed [COORD_WIDTH:0]   m_row_above,
    output logic signed [COORD_WIDTH:0]   m_span_left,
    output logic signed [COORD_WIDTH:0]   m_span_right,
    output logic        [COLOR_W-1:0]     m_color_out,
    output logic                          m_last_span
);

    localparam int OW = COORD_WIDTH + 1;

    fcsg_state_t state_reg, state_next;

    logic [COORD_WIDTH-1:0] cx_reg, cx_next;
    logic [COORD_WIDTH-1:0] cy_reg, cy_next;
    logic [RADIUS_W-1:0]    r_reg, r_next;
    logic [RADIUS_W-1:0]    dy_reg, dy_next;
    logic [COLOR_W-1:0]     color_reg, color_next;

    logic [OW-1:0]          row_below_reg, row_below_next;
    logic [OW-1:0]          row_above_reg, row_above_next;
    logic [OW-1:0]          left_reg, left_next;
    logic [OW-1:0]          right_reg, right_next;
    logic                   last_reg, last_next;

    logic [RADIUS_W-1:0]    r_sat;
    logic [RADIUS_W:0]      two_r_minus_dy;
    logic [PROD_W-1:0]      prod_full;
    logic                   sqrt_start;
    fcsg_root_t             root;

    logic [OW-1:0]          cx_ext, cy_ext, r_ext, dy_ext, dx_ext;

    assign r_sat = (int'(s_radius) > RADIUS_MAX) ? RADIUS_W'(RADIUS_MAX) : s_radius;

    // dy * (2r - dy) never exceeds r*r, so it fits the operand width
    assign two_r_minus_dy = {r_reg, 1'b0} - {1'b0, dy_reg};
    assign prod_full      = PROD_W'(dy_reg) * PROD_W'(two_r_minus_dy);

    assign cx_ext = {cx_reg[COORD_WIDTH-1], cx_reg};
    assign cy_ext = {cy_reg[COORD_WIDTH-1], cy_reg};
    assign r_ext  = {{(OW-RADIUS_W){1'b0}}, r_reg};
    assign dy_ext = {{(OW-RADIUS_W){1'b0}}, dy_reg};
    assign dx_ext = {{(OW-ROOT_W){1'b0}}, root.root};

    fcsg_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .operand (prod_full),
        .result  (root)
    );

    always_comb begin
        state_next     = state_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        r_next         = r_reg;
        dy_next        = dy_reg;
        color_next     = color_reg;
        row_below_next = row_below_reg;
        row_above_next = row_above_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        last_next      = last_reg;
        s_ready        = 1'b0;
        m_valid        = 1'b0;
        sqrt_start     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cx_next    = s_center_x;
                    cy_next    = s_center_y;
                    r_next     = r_sat;
                    dy_next    = RADIUS_W'(1);
                    color_next = s_fill_color;
                    if (r_sat != '0) begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                sqrt_start = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (root.done) begin
                    row_below_next = cy_ext + r_ext - dy_ext;
                    row_above_next = cy_ext - r_ext + dy_ext;
                    left_next      = cx_ext - dx_ext;
                    right_next     = cx_ext + dx_ext;
                    last_next      = (dy_reg == r_reg);
                    state_next     = ST_OUT;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        dy_next    = dy_reg + 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        r_reg         <= r_next;
        dy_reg        <= dy_next;
        color_reg     <= color_next;
        row_below_reg <= row_below_next;
        row_above_reg <= row_above_next;
        left_reg      <= left_next;
        right_reg     <= right_next;
        last_reg      <= last_next;
    end

    assign m_row_below  = row_below_reg;
    assign m_row_above  = row_above_reg;
    assign m_span_left  = left_reg;
    assign m_span_right = right_reg;
    assign m_color_out  = color_reg;
    assign m_last_span  = last_reg;

endmodule

@@ sim/tb_filled_circle_span_generator.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the filled circle span generator.
module tb_filled_circle_span_generator;
    import fcsg_pkg::*;

    localparam int COORD_W      = COORD_WIDTH_DEF;
    localparam int RADIUS_LIMIT = RADIUS_MAX_DEF;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 12 * RADIUS_LIMIT;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct {
        logic signed [COORD_W:0] row_below;
        logic signed [COORD_W:0] row_above;
        logic signed [COORD_W:0] span_left;
        logic signed [COORD_W:0] span_right;
        logic [COLOR_W-1:0]      color;
        logic                    is_last;
    } span_pair_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic signed [COORD_W-1:0]   s_center_x = '0;
    logic signed [COORD_W-1:0]   s_center_y = '0;
    logic [RADIUS_W-1:0]         s_radius = '0;
    logic [COLOR_W-1:0]          s_fill_color = '0;

    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic signed [COORD_W:0]     m_row_below;
    logic signed [COORD_W:0]     m_row_above;
    logic signed [COORD_W:0]     m_span_left;
    logic signed [COORD_W:0]     m_span_right;
    logic [COLOR_W-1:0]          m_color_out;
    logic                        m_last_span;

    span_pair_t expected_spans[$];
    int  error_count = 0;
    int  cycle_count = 0;
    bit  sender_idle = 1'b1;
    bit  receiver_idle = 1'b1;
    bit  hold_request = 1'b0;

    filled_circle_span_generator #(
        .RADIUS_MAX  (RADIUS_LIMIT),
        .COORD_WIDTH (COORD_W)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_center_x   (s_center_x),
        .s_center_y   (s_center_y),
        .s_radius     (s_radius),
        .s_fill_color (s_fill_color),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_row_below  (m_row_below),
        .m_row_above  (m_row_above),
        .m_span_left  (m_span_left),
        .m_span_right (m_span_right),
        .m_color_out  (m_color_out),
        .m_last_span  (m_last_span)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // largest root with root*root <= v, by counting up
    function automatic int floor_sqrt(int v);
        int root;
        root = 0;
        while ((root + 1) * (root + 1) <= v)
            root++;
        return root;
    endfunction

    function automatic void predict_spans(logic signed [COORD_W-1:0] cx,
                                          logic signed [COORD_W-1:0] cy,
                                          logic [RADIUS_W-1:0] r,
                                          logic [COLOR_W-1:0] color);
        int rad;
        int dx;
        span_pair_t pair;
        rad = (r > RADIUS_LIMIT) ? RADIUS_LIMIT : int'(r);
        for (int dy = 1; dy <= rad; dy++) begin
            dx = floor_sqrt(dy * (2 * rad - dy));
            pair.row_below  = (COORD_W+1)'(int'(cy) + rad - dy);
            pair.row_above  = (COORD_W+1)'(int'(cy) - rad + dy);
            pair.span_left  = (COORD_W+1)'(int'(cx) - dx);
            pair.span_right = (COORD_W+1)'(int'(cx) + dx);
            pair.color      = color;
            pair.is_last    = (dy == rad);
            expected_spans.push_back(pair);
        end
    endfunction

    // called just after a rising edge; returns just after the accepting edge
    task automatic send_circle(logic signed [COORD_W-1:0] cx,
                               logic signed [COORD_W-1:0] cy,
                               logic [RADIUS_W-1:0] r,
                               logic [COLOR_W-1:0] color);
        if (sender_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_center_x   <= cx;
        s_center_y   <= cy;
        s_radius     <= r;
        s_fill_color <= color;
        do @(posedge aclk); while (!s_ready);
        predict_spans(cx, cy, r, color);
    endtask

    function automatic logic [RADIUS_W-1:0] pick_radius();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            return '0;
        else if (sel < 80)
            return RADIUS_W'($urandom_range(1, 12));
        else if (sel < 95)
            return RADIUS_W'($urandom_range(13, RADIUS_LIMIT));
        return RADIUS_W'($urandom_range(RADIUS_LIMIT + 1, (1 << RADIUS_W) - 1));
    endfunction

    task automatic send_random_circle();
        send_circle(COORD_W'($urandom), COORD_W'($urandom), pick_radius(), $urandom);
    endtask

    // receiver side: random stalls, plus one long hold on request
    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
                m_ready <= 1'b1;
            end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic void compare_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        span_pair_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_spans.size() == 0) begin
                $error("span transaction with nothing outstanding");
                error_count++;
            end else begin
                want = expected_spans.pop_front();
                compare_field("row_below", longint'(want.row_below),
                              longint'(m_row_below));
                compare_field("row_above", longint'(want.row_above),
                              longint'(m_row_above));
                compare_field("span_left", longint'(want.span_left),
                              longint'(m_span_left));
                compare_field("span_right", longint'(want.span_right),
                              longint'(m_span_right));
                compare_field("color_out", longint'(want.color),
                              longint'(m_color_out));
                compare_field("last_span", longint'(want.is_last),
                              longint'(m_last_span));
            end
        end
    end

    task automatic test_radius_extremes();
        send_circle(12'sd0, 12'sd0, 7'd0, 32'h0000_0000);
        send_circle(12'sd0, 12'sd0, 7'd1, 32'hFFFF_FFFF);
        send_circle(12'sd2047, 12'sd2047, 7'd64, 32'hA5A5_5A5A);
        send_circle(-12'sd2048, -12'sd2048, 7'd64, 32'h5A5A_A5A5);
        // over-range radii saturate
        send_circle(12'sd2047, -12'sd2048, 7'd65, 32'h1234_5678);
        send_circle(-12'sd2048, 12'sd2047, 7'd127, 32'hFFFF_FFFF);
        send_circle(-12'sd1, -12'sd1, 7'd0, 32'hFFFF_FFFF);
        send_circle(12'sd100, -12'sd100, 7'd2, 32'h0000_0001);
        send_circle(-12'sd1, 12'sd1, 7'd3, 32'h8000_0000);
        send_circle(12'sd5, 12'sd5, 7'd63, $urandom);
        send_circle(12'sd0, 12'sd0, 7'd0, 32'hDEAD_BEEF);
        send_circle(-12'sd700, 12'sd900, 7'd100, $urandom);
    endtask

    // sender keeps offering while the result side is held off
    task automatic test_output_stall();
        hold_request = 1'b1;
        repeat (5)
            send_circle(COORD_W'($urandom), COORD_W'($urandom), 7'd3, $urandom);
    endtask

    task automatic test_random_circles(int count);
        repeat (count)
            send_random_circle();
    endtask

    task automatic test_back_to_back(int count);
        sender_idle = 1'b0;
        receiver_idle = 1'b0;
        repeat (count)
            send_random_circle();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_radius_extremes();
        test_output_stall();
        test_random_circles(130);
        test_back_to_back(25);

        s_valid <= 1'b0;
        while (expected_spans.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
